[hdl/mrpc_pkg.sv]
// Shared constants and types of the mixed-radix path codec.
package mrpc_pkg;

  localparam int CODE_W            = 64;
  localparam int RADIX_W           = 8;
  localparam int DIGIT_W           = 8;
  localparam int KIND_W            = 2;
  localparam int CFG_W             = 5;
  localparam int POS_OUT_W         = 4;
  localparam int DEF_MAX_POSITIONS = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_DECODE = 2'd2
  } kind_t;

endpackage

[hdl/mrpc_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module mrpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mrpc_pkg::CODE_W-1:0] dividend,
  input  logic [mrpc_pkg::CODE_W-1:0] divisor,
  output logic                        done,
  output logic [mrpc_pkg::CODE_W-1:0] quotient,
  output logic [mrpc_pkg::CODE_W-1:0] remainder
);

  localparam int W  = mrpc_pkg::CODE_W;
  localparam int NW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] cnt_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  dvs_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          take;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign take    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == NW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], take};
      rem_r <= take ? diff[W-1:0] : shifted[W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hdl/mixed_radix_path_codec_unit.sv]
// Top level of the mixed-radix path codec: place-value memory, sequencer and result register.
//
// One item is taken at a time; in_stall is low only while the sequencer is idle. A load item
// and an encode item each run a 64-by-8 product as two 32-bit halves, and an encode item
// also posts the identifier on the last digit. For each position in use (up to 16
// positions by default), a decode item reads the place value from the place-value
// memory, divides in the one-bit-per-cycle divider and posts the digit. A waiting result
// sits in the output register and does not block the next input item.
module mixed_radix_path_codec_unit #(
  parameter int MAX_POSITIONS = mrpc_pkg::DEF_MAX_POSITIONS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrpc_pkg::CFG_W-1:0]      cfg_position_count,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrpc_pkg::KIND_W-1:0]     in_kind,
  input  logic [mrpc_pkg::RADIX_W-1:0]    in_radix,
  input  logic [mrpc_pkg::DIGIT_W-1:0]    in_digit,
  input  logic [mrpc_pkg::CODE_W-1:0]     in_path_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrpc_pkg::CODE_W-1:0]     out_code_out,
  output logic [mrpc_pkg::POS_OUT_W-1:0]  out_position_out,
  output logic [mrpc_pkg::DIGIT_W-1:0]    out_digit_out,
  output logic                            out_last_out,
  output logic                            out_error_out
);

  localparam int W  = mrpc_pkg::CODE_W;
  localparam int RW = mrpc_pkg::RADIX_W;
  localparam int DW = mrpc_pkg::DIGIT_W;
  localparam int HW = W / 2;
  localparam int MW = HW + RW;
  localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int CW = $clog2(MAX_POSITIONS + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RD     = 7'b0000010,
    ST_MUL_LO = 7'b0000100,
    ST_MUL_HI = 7'b0001000,
    ST_ACC    = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [mrpc_pkg::CFG_W-1:0] cfg_r;
  logic [CW-1:0]             cnt_eff;
  logic [PW-1:0]             lp_r;
  logic [PW-1:0]             ep_r;
  logic [PW-1:0]             pos_r;
  logic                      ovf_r;
  logic [W-1:0]              rp_r;
  logic [W-1:0]              sum_r;
  mrpc_pkg::kind_t           kind_r;
  logic [W-1:0]              mcand_r;
  logic [RW-1:0]             factor_r;
  logic [MW-1:0]             prod_lo_r;
  logic [MW-1:0]             prod_hi_r;
  logic [W+RW-1:0]           full;
  logic                      mul_ovf;
  logic [W-1:0]              sum_new;
  logic                      enc_done;
  logic [W-1:0]              rem_r;
  logic [W-1:0]              base;
  logic                      slot_free;
  logic                      accept;

  logic [W-1:0]              pv_mem_r [MAX_POSITIONS];
  logic [W-1:0]              rd_data_r;
  logic                      mem_we;
  logic [PW-1:0]             mem_raddr;

  logic                      div_start;
  logic                      div_done;
  logic [W-1:0]              div_quo;
  logic [W-1:0]              div_rem;
  logic                      sat;

  logic [W-1:0]              res_code_r;
  logic [mrpc_pkg::POS_OUT_W-1:0] res_pos_r;
  logic [DW-1:0]             res_digit_r;
  logic                      res_last_r;
  logic                      res_err_r;
  logic                      out_valid_r;
  logic [W-1:0]              out_code_r;
  logic [mrpc_pkg::POS_OUT_W-1:0] out_pos_r;
  logic [DW-1:0]             out_digit_r;
  logic                      out_last_r;
  logic                      out_err_r;

  always_comb begin
    if (cfg_r == '0) begin
      cnt_eff = CW'(1);
    end else if (32'(cfg_r) > MAX_POSITIONS) begin
      cnt_eff = CW'(MAX_POSITIONS);
    end else begin
      cnt_eff = CW'(cfg_r);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign base      = (lp_r == '0) ? W'(1) : rp_r;
  assign full      = {prod_hi_r, {HW{1'b0}}} + {{HW{1'b0}}, prod_lo_r};
  assign mul_ovf   = |full[W+RW-1:W];
  assign sum_new   = sum_r + full[W-1:0];
  assign enc_done  = (32'(ep_r) + 32'd1) >= 32'(cnt_eff);
  assign sat       = |div_quo[W-1:DW];
  assign div_start = (state_r == ST_RD) && (kind_r == mrpc_pkg::KIND_DECODE);
  assign mem_we    = accept && (in_kind == mrpc_pkg::KIND_LOAD);

  always_comb begin
    unique case (state_r)
      ST_IDLE: mem_raddr = (in_kind == mrpc_pkg::KIND_DECODE) ? PW'(cnt_eff - 1'b1) : ep_r;
      ST_EMIT: mem_raddr = pos_r - 1'b1;
      default: mem_raddr = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) pv_mem_r[lp_r] <= base;
    rd_data_r <= pv_mem_r[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            mrpc_pkg::KIND_LOAD:   state_nxt = ST_MUL_LO;
            mrpc_pkg::KIND_ENCODE: state_nxt = ST_RD;
            mrpc_pkg::KIND_DECODE: state_nxt = ST_RD;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:     state_nxt = (kind_r == mrpc_pkg::KIND_DECODE) ? ST_DIV : ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_ACC;
      ST_ACC: begin
        if (kind_r == mrpc_pkg::KIND_ENCODE && enc_done) state_nxt = ST_EMIT;
        else state_nxt = ST_IDLE;
      end
      ST_DIV:  if (div_done) state_nxt = ST_EMIT;
      ST_EMIT: if (slot_free) state_nxt = res_last_r ? ST_IDLE : ST_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= mrpc_pkg::CFG_W'(1);
      lp_r        <= '0;
      ep_r        <= '0;
      ovf_r       <= 1'b0;
      rp_r        <= W'(1);
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) cfg_r <= cfg_position_count;
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (mem_we) begin
            if (lp_r == '0) ovf_r <= 1'b0;
            lp_r <= (32'(lp_r) == MAX_POSITIONS - 1) ? '0 : lp_r + 1'b1;
          end
        end
        ST_ACC: begin
          if (kind_r == mrpc_pkg::KIND_LOAD) begin
            rp_r  <= mul_ovf ? '1 : full[W-1:0];
            ovf_r <= ovf_r | mul_ovf;
          end else if (enc_done) begin
            ep_r  <= '0;
            sum_r <= '0;
          end else begin
            ep_r  <= ep_r + 1'b1;
            sum_r <= sum_new;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_r <= mrpc_pkg::kind_t'(in_kind);
          unique case (in_kind)
            mrpc_pkg::KIND_LOAD: begin
              mcand_r  <= base;
              factor_r <= (in_radix == '0) ? RW'(1) : in_radix;
            end
            mrpc_pkg::KIND_ENCODE: factor_r <= in_digit;
            mrpc_pkg::KIND_DECODE: begin
              rem_r <= in_path_code;
              pos_r <= PW'(cnt_eff - 1'b1);
            end
            default: ;
          endcase
        end
      end
      ST_RD:     if (kind_r == mrpc_pkg::KIND_ENCODE) mcand_r <= rd_data_r;
      ST_MUL_LO: prod_lo_r <= MW'(factor_r) * MW'(mcand_r[HW-1:0]);
      ST_MUL_HI: prod_hi_r <= MW'(factor_r) * MW'(mcand_r[W-1:HW]);
      ST_ACC: begin
        res_code_r  <= sum_new;
        res_pos_r   <= '0;
        res_digit_r <= '0;
        res_last_r  <= 1'b1;
        res_err_r   <= ovf_r;
      end
      ST_DIV: begin
        if (div_done) begin
          rem_r       <= div_rem;
          res_code_r  <= '0;
          res_pos_r   <= mrpc_pkg::POS_OUT_W'(pos_r);
          res_digit_r <= sat ? '1 : div_quo[DW-1:0];
          res_last_r  <= (pos_r == '0);
          res_err_r   <= ovf_r | sat;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_code_r  <= res_code_r;
          out_pos_r   <= res_pos_r;
          out_digit_r <= res_digit_r;
          out_last_r  <= res_last_r;
          out_err_r   <= res_err_r;
          if (!res_last_r) pos_r <= pos_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  mrpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_r),
    .divisor   (rd_data_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_valid        = out_valid_r;
  assign out_code_out     = out_code_r;
  assign out_position_out = out_pos_r;
  assign out_digit_out    = out_digit_r;
  assign out_last_out     = out_last_r;
  assign out_error_out    = out_err_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free && res_last_r) |=> state_r == ST_IDLE)
    else $error("sequencer kept running after the last beat");

  a_pos_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free && !res_last_r) |=>
      (pos_r == $past(pos_r) - 1'b1 && state_r == ST_RD))
    else $error("decode position did not step down");

  a_code_beat_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code_out != '0) |-> (out_position_out == '0 && out_digit_out == '0
      && out_last_out))
    else $error("identifier beat carries digit fields");

endmodule
